>>> hdl/assert_macros.svh
// Assertion macros used by the RTL of the footer checker.
// No dependencies; clock and reset are passed in by each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a plain condition on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    `ASSERT_PROP(label, clk, rst_n, cond, msg)
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`endif
`endif

>>> hdl/rifc_pkg.sv
// Package for the ROM image footer checker: sizes, footer codes, verdict type
// and the declared-size lookup. No dependencies.
package rifc_pkg;

    localparam int unsigned MAX_IMAGE_BYTES   = 16777216;
    // Bank size must be a power of two: the multiple check is a low-bit mask.
    localparam int unsigned BANK_BYTES        = 65536;
    localparam int unsigned MIN_COMPACT_BYTES = 65536;

    localparam int unsigned FOOTER_LEN = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned MAPPED_W   = 25;
    localparam int unsigned DECL_W     = 25;
    localparam int unsigned CNT_W      = $clog2(MAX_IMAGE_BYTES + 2);
    localparam int unsigned APT_W      = CNT_W + 1;
    localparam int unsigned CMP_W      = (APT_W > DECL_W) ? APT_W : DECL_W;
    localparam int unsigned BANK_LOG2  = $clog2(BANK_BYTES);
    localparam int unsigned WIN_IDX_W  = $clog2(FOOTER_LEN);

    // Footer byte offsets
    localparam logic [WIN_IDX_W-1:0] F_SIGNATURE = 0;
    localparam logic [WIN_IDX_W-1:0] F_FLAGS_A   = 5;
    localparam logic [WIN_IDX_W-1:0] F_COLOR     = 7;
    localparam logic [WIN_IDX_W-1:0] F_SIZE      = 10;
    localparam logic [WIN_IDX_W-1:0] F_SAVE      = 11;
    localparam logic [WIN_IDX_W-1:0] F_FLAGS_B   = 12;
    localparam logic [WIN_IDX_W-1:0] F_MAPPER    = 13;
    localparam logic [WIN_IDX_W-1:0] F_CSUM_LO   = 14;
    localparam logic [WIN_IDX_W-1:0] F_CSUM_HI   = 15;

    localparam logic [7:0] SIGNATURE_BYTE = 8'hea;
    localparam logic [7:0] FLAGS_A_MASK   = 8'h0f;
    localparam logic [7:0] FLAGS_B_BIT    = 8'h04;
    localparam logic [7:0] SAVE_MAX_SMALL = 8'h05;
    localparam logic [7:0] SAVE_CODE_A    = 8'h10;
    localparam logic [7:0] SAVE_CODE_B    = 8'h20;
    localparam logic [7:0] SAVE_CODE_C    = 8'h50;
    localparam logic [7:0] SIZE_CODE_LAST = 8'h09;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic                status;
        logic [MAPPED_W-1:0] aperture_bytes;
        logic [SUM_W-1:0]    footer_cksum;
        logic [SUM_W-1:0]    image_cksum;
        logic                color_flag;
        logic [7:0]          save_kind;
        logic [7:0]          mapper_code;
        logic [7:0]          size_code;
        logic                checksum_ok;
        logic                footer_ok;
        logic                compact_flag;
        logic                clock_present;
    } t_verdict;

    // Declared image size for a footer size code; unknown codes give zero.
    function automatic logic [DECL_W-1:0] decl_size(input logic [7:0] code);
        logic [DECL_W-1:0] kib;
        kib = DECL_W'(1024);
        unique case (code)
            8'h00:   decl_size = kib * DECL_W'(128);
            8'h01:   decl_size = kib * DECL_W'(256);
            8'h02:   decl_size = kib * DECL_W'(512);
            8'h03:   decl_size = kib * DECL_W'(1024);
            8'h04:   decl_size = kib * DECL_W'(2048);
            8'h05:   decl_size = kib * DECL_W'(3072);
            8'h06:   decl_size = kib * DECL_W'(4096);
            8'h07:   decl_size = kib * DECL_W'(6144);
            8'h08:   decl_size = kib * DECL_W'(8192);
            SIZE_CODE_LAST: decl_size = kib * DECL_W'(16384);
            default: decl_size = '0;
        endcase
    endfunction

endpackage

>>> hdl/rifc_stream_if.sv
// Valid/ready stream interfaces for the footer checker's input bytes and verdicts.
// Depends on rifc_pkg for field widths.
interface rifc_in_if import rifc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rom_byte;
    logic  end_of_image;

    modport source (output valid, output rom_byte, output end_of_image, input ready);
    modport sink   (input valid, input rom_byte, input end_of_image, output ready);
endinterface

interface rifc_out_if import rifc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                status;
    logic [MAPPED_W-1:0] aperture_bytes;
    logic [SUM_W-1:0]    footer_cksum;
    logic [SUM_W-1:0]    image_cksum;
    logic                color_flag;
    logic [7:0]          save_kind;
    logic [7:0]          mapper_code;
    logic [7:0]          size_code;
    logic                checksum_ok;
    logic                footer_ok;
    logic                compact_flag;
    logic                clock_present;

    modport source (
        output valid, output status, output aperture_bytes, output footer_cksum,
        output image_cksum, output color_flag, output save_kind,
        output mapper_code, output size_code, output checksum_ok, output footer_ok,
        output compact_flag, output clock_present, input ready
    );
    modport sink (
        input valid, input status, input aperture_bytes, input footer_cksum,
        input image_cksum, input color_flag, input save_kind,
        input mapper_code, input size_code, input checksum_ok, input footer_ok,
        input compact_flag, input clock_present, output ready
    );
endinterface

>>> hdl/rom_image_footer_check.sv
// ROM image footer checker, top level.
// Depends on rifc_pkg, rifc_stream_if.sv and assert_macros.svh.
//
// Usage:
// - i_in carries one image byte per transaction, in file order; end_of_image
//   marks the final byte of an image. The next byte after it starts a new image.
// - o_out carries one verdict transaction per image, issued for the final byte
//   only; other bytes produce nothing on o_out.
// - Throughput: one byte per cycle, sustained while no final byte waits for
//   o_out. The byte lands in an input register; from there it updates the
//   running sum, count and 16-byte tail window and, for a final byte, evaluates
//   the footer into the verdict register, which drives o_out.valid.
// - Stall: a waiting verdict in the output register does not block non-final
//   bytes; only a second final byte waits until the first verdict is taken.
// - Images under 16 bytes or over MAX_IMAGE_BYTES give status 1 with every other
//   field zero; the count saturates one past the maximum and flags overflow.
// - Reset (i_rst_n low, synchronous) clears the sum, count, window and both
//   valid flags; there is no clearing pass.
`include "assert_macros.svh"

module rom_image_footer_check import rifc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rifc_in_if.sink   i_in,
    rifc_out_if.source o_out
);

    // Input register
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_last;

    // Running image state
    logic [SUM_W-1:0] r_sum,   n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf,   n_ovf;
    t_byte            r_win [FOOTER_LEN];
    t_byte            n_win [FOOTER_LEN];

    // Result register
    logic     r_out_valid;
    t_verdict r_out, n_out;

    logic out_free;
    logic adv;
    logic sat;

    // Advance the input stage: non-final bytes always go, a final byte needs
    // room in the result register.
    assign out_free   = !r_out_valid || o_out.ready;
    assign adv        = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready) begin
            r_in_byte <= i_in.rom_byte;
            r_in_last <= i_in.end_of_image;
        end
    end

    // Next state with the held byte folded in; these values describe the image.
    assign sat     = r_count > CNT_W'(MAX_IMAGE_BYTES - 1);
    assign n_sum   = r_sum + SUM_W'(r_in_byte);
    assign n_count = sat ? CNT_W'(MAX_IMAGE_BYTES + 1) : r_count + CNT_W'(1);
    assign n_ovf   = r_ovf || sat;

    always_comb begin
        for (int k = 0; k < FOOTER_LEN - 1; k++) begin
            n_win[k] = r_win[k+1];
        end
        n_win[FOOTER_LEN-1] = r_in_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            for (int k = 0; k < FOOTER_LEN; k++) r_win[k] <= '0;
        end else if (adv) begin
            if (r_in_last) begin
                // Drop all image state after the verdict.
                r_sum   <= '0;
                r_count <= '0;
                r_ovf   <= 1'b0;
                for (int k = 0; k < FOOTER_LEN; k++) r_win[k] <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
                r_ovf   <= n_ovf;
                for (int k = 0; k < FOOTER_LEN; k++) r_win[k] <= n_win[k];
            end
        end
    end

    // Footer evaluation
    logic [SUM_W-1:0]  computed, stored;
    logic [DECL_W-1:0] declared;
    logic [APT_W-1:0]  lead, aperture;
    logic              p2, compact, size_match, fok, reject, save_good, rules_ok;

    always_comb begin
        computed = n_sum - SUM_W'(n_win[F_CSUM_LO]) - SUM_W'(n_win[F_CSUM_HI]);
        stored   = {n_win[F_CSUM_HI], n_win[F_CSUM_LO]};
        declared = decl_size(n_win[F_SIZE]);

        p2 = (n_count != '0) && ((n_count & (n_count - CNT_W'(1))) == '0);

        // Highest set bit of the size; one step up gives the aperture.
        lead = '0;
        for (int k = 0; k < CNT_W; k++) begin
            if (n_count[k]) lead = APT_W'(1) << k;
        end
        aperture = p2 ? APT_W'(n_count) : (lead << 1);

        compact = !p2
               && (n_count >= CNT_W'(MIN_COMPACT_BYTES))
               && (n_count[BANK_LOG2-1:0] == '0)
               && (aperture <= APT_W'(MAX_IMAGE_BYTES));

        size_match = (declared != '0)
                  && ((CMP_W'(declared) == CMP_W'(n_count))
                   || (CMP_W'(declared) == CMP_W'(aperture)));

        save_good = (n_win[F_SAVE] <= SAVE_MAX_SMALL) || (n_win[F_SAVE] == SAVE_CODE_A)
                 || (n_win[F_SAVE] == SAVE_CODE_B) || (n_win[F_SAVE] == SAVE_CODE_C);

        rules_ok = (n_win[F_SIGNATURE] == SIGNATURE_BYTE)
                && ((n_win[F_FLAGS_A] & FLAGS_A_MASK) == '0)
                && (n_win[F_COLOR] <= 8'd1)
                && save_good
                && ((n_win[F_FLAGS_B] & FLAGS_B_BIT) != '0)
                && (n_win[F_MAPPER] <= 8'd1);

        fok = rules_ok && (stored == computed) && (p2 || size_match);

        reject = n_ovf || (n_count < CNT_W'(FOOTER_LEN))
              || (n_count > CNT_W'(MAX_IMAGE_BYTES));

        if (reject) begin
            n_out        = '0;
            n_out.status = 1'b1;
        end else begin
            n_out.status         = !p2 && (!compact || !fok);
            n_out.aperture_bytes = MAPPED_W'(aperture);
            n_out.footer_cksum   = stored;
            n_out.image_cksum    = computed;
            n_out.color_flag     = n_win[F_COLOR] == 8'd1;
            n_out.save_kind      = n_win[F_SAVE];
            n_out.mapper_code    = n_win[F_MAPPER];
            n_out.size_code      = n_win[F_SIZE];
            n_out.checksum_ok    = stored == computed;
            n_out.footer_ok      = fok;
            n_out.compact_flag   = !p2;
            n_out.clock_present  = n_win[F_MAPPER] == 8'd1;
        end
    end

    // Result register: load on a final byte, hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.aperture_bytes = r_out.aperture_bytes;
    assign o_out.footer_cksum   = r_out.footer_cksum;
    assign o_out.image_cksum    = r_out.image_cksum;
    assign o_out.color_flag     = r_out.color_flag;
    assign o_out.save_kind      = r_out.save_kind;
    assign o_out.mapper_code    = r_out.mapper_code;
    assign o_out.size_code      = r_out.size_code;
    assign o_out.checksum_ok    = r_out.checksum_ok;
    assign o_out.footer_ok      = r_out.footer_ok;
    assign o_out.compact_flag   = r_out.compact_flag;
    assign o_out.clock_present  = r_out.clock_present;

    // Assertions
    `ASSERT_PROP(a_mid_byte_flows, i_clk, i_rst_n,
        (r_in_valid && !r_in_last) |-> adv, "non-final byte stalled")
    `ASSERT_PROP(a_clear_after_last, i_clk, i_rst_n,
        (adv && r_in_last) |=> (r_count == '0 && r_sum == '0 && !r_ovf),
        "state not cleared after verdict")
    `ASSERT_PROP(a_verdict_loaded, i_clk, i_rst_n,
        (adv && r_in_last) |=> r_out_valid, "verdict missing after final byte")
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        r_count <= CNT_W'(MAX_IMAGE_BYTES + 1), "byte count past saturation")
    `ASSERT_ALWAYS(a_ovf_saturated, i_clk, i_rst_n,
        !r_ovf || (r_count == CNT_W'(MAX_IMAGE_BYTES + 1)),
        "overflow flag without saturated count")

endmodule

>>> dv/tb_rom_image_footer_check.sv
`timescale 1ns / 100ps
// Testbench for rom_image_footer_check: streams cartridge images with built footers
// and checks each verdict against a footer predictor kept inside the bench.
// Depends on rifc_pkg and the rifc_in_if / rifc_out_if interfaces.
module tb_rom_image_footer_check;
    import rifc_pkg::*;

    // A cycle count with no transaction on either side that means the block hung.
    localparam int unsigned QUIET_LIMIT  = 2000;
    // The verdict leaves through the result register after the final byte; leave a little margin.
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int          FILL_RANDOM  = -1;

    // Declared image sizes in KiB, indexed by the footer size code.
    localparam int unsigned DECLARED_KIB [10] = '{
        128, 256, 512, 1024, 2048, 3072, 4096, 6144, 8192, 16384
    };
    localparam t_byte SIZE_CODE_128K = 8'h00;
    localparam t_byte SIZE_CODE_256K = 8'h01;

    // Ways a built footer can break one rule; noise replaces the whole footer.
    typedef enum int {
        FLAW_NONE, FLAW_SIGNATURE, FLAW_FLAGS_A, FLAW_COLOR, FLAW_SAVE,
        FLAW_FLAGS_B, FLAW_MAPPER, FLAW_CHECKSUM, FLAW_NOISE
    } t_flaw;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rifc_in_if  in_if ();
    rifc_out_if out_if ();

    rom_image_footer_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Running state of the image being predicted.
    logic [SUM_W-1:0] run_sum;
    int unsigned      run_count;
    bit               run_overflow;
    t_byte            tail [FOOTER_LEN];
    t_verdict         verdicts_due [$];

    int          errors = 0;
    bit          stall_on = 1'b0;    // random verdict-side stalls enabled
    int unsigned gap_odds = 0;       // one byte in gap_odds gets a gap before it; 0 for none
    int unsigned stall_left = 0;
    int unsigned quiet = 0;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Footer predictor
    // ------------------------------------------------------------------
    function automatic bit save_code_ok(input t_byte c);
        return c <= SAVE_MAX_SMALL || c == SAVE_CODE_A || c == SAVE_CODE_B ||
               c == SAVE_CODE_C;
    endfunction

    function automatic void clear_image();
        run_sum      = '0;
        run_count    = 0;
        run_overflow = 1'b0;
        foreach (tail[k]) tail[k] = '0;
    endfunction

    // Evaluate the footer held in the tail window for the image just ended.
    function automatic t_verdict judge_image();
        t_verdict          v;
        int unsigned       size;
        int unsigned       declared;
        longint unsigned   aperture;
        logic [SUM_W-1:0]  stored;
        logic [SUM_W-1:0]  computed;
        bit                p2;
        bit                compact;
        bit                size_match;
        bit                fok;
        v    = '0;
        size = run_count;
        // Too short, too long or saturated: reject with every other field zero.
        if (run_overflow || size < FOOTER_LEN || size > MAX_IMAGE_BYTES) begin
            v.status = 1'b1;
            return v;
        end
        // The two checksum bytes are themselves part of the running sum: take them out.
        computed = run_sum - SUM_W'(tail[F_CSUM_LO]) - SUM_W'(tail[F_CSUM_HI]);
        stored   = {tail[F_CSUM_HI], tail[F_CSUM_LO]};
        // Size codes past the table declare nothing, which never matches.
        declared = (tail[F_SIZE] <= SIZE_CODE_LAST) ?
                   DECLARED_KIB[tail[F_SIZE][3:0]] * 1024 : 0;
        p2       = (size & (size - 1)) == 0;
        aperture = 1;
        while (aperture < size && aperture <= MAX_IMAGE_BYTES) aperture <<= 1;
        compact  = !p2 && size >= MIN_COMPACT_BYTES && (size % BANK_BYTES) == 0 &&
                   aperture <= MAX_IMAGE_BYTES;
        size_match = declared != 0 && (declared == size || declared == aperture);
        fok      = tail[F_SIGNATURE] == SIGNATURE_BYTE &&
                   (tail[F_FLAGS_A] & FLAGS_A_MASK) == '0 &&
                   tail[F_COLOR] <= 1 && save_code_ok(tail[F_SAVE]) &&
                   (tail[F_FLAGS_B] & FLAGS_B_BIT) != '0 &&
                   tail[F_MAPPER] <= 1 && stored == computed && (p2 || size_match);
        // A power-of-two image is always accepted; otherwise it must be compact and clean.
        v.status         = !p2 && (!compact || !fok);
        v.aperture_bytes = aperture[MAPPED_W-1:0];
        v.footer_cksum   = stored;
        v.image_cksum    = computed;
        v.color_flag     = tail[F_COLOR] == 8'd1;
        v.save_kind      = tail[F_SAVE];
        v.mapper_code    = tail[F_MAPPER];
        v.size_code      = tail[F_SIZE];
        v.checksum_ok    = stored == computed;
        v.footer_ok      = fok;
        v.compact_flag   = !p2;
        v.clock_present  = tail[F_MAPPER] == 8'd1;
        return v;
    endfunction

    // Advance the predictor by one accepted byte; a final byte queues its verdict.
    function automatic void account_byte(input t_byte b, input logic last);
        int unsigned k;
        for (k = 0; k < FOOTER_LEN - 1; k++) tail[k] = tail[k + 1];
        tail[FOOTER_LEN - 1] = b;
        run_sum = run_sum + SUM_W'(b);
        if (run_count > MAX_IMAGE_BYTES - 1) begin
            run_overflow = 1'b1;
            run_count    = MAX_IMAGE_BYTES + 1;
        end else begin
            run_count++;
        end
        if (last) begin
            verdicts_due.push_back(judge_image());
            clear_image();
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------
    // Called at a rising edge; returns at the edge that accepted the byte.
    // Valid stays high from one byte to the next unless a gap is inserted.
    task automatic send_byte(input t_byte b, input logic last);
        if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.rom_byte     <= b;
        in_if.end_of_image <= last;
        do @(posedge i_clk); while (!(in_if.valid === 1'b1 && in_if.ready === 1'b1));
        account_byte(b, last);
    endtask

    function automatic t_byte pick_byte(input int fill);
        return (fill == FILL_RANDOM) ? t_byte'($urandom) : t_byte'(fill);
    endfunction

    // Stream one image of the given size. From 16 bytes up, the last 16 form a
    // footer that follows every rule except the one the flaw breaks, with a
    // checksum over everything before its own two bytes; a noise footer is all random.
    task automatic send_image(input int unsigned size, input t_flaw flaw,
                              input t_byte code, input int fill);
        t_byte            foot [FOOTER_LEN];
        logic [SUM_W-1:0] csum;
        t_byte            b;
        int unsigned      k;
        csum = '0;
        if (size < FOOTER_LEN) begin
            for (k = 0; k < size; k++) send_byte(pick_byte(fill), k == size - 1);
            return;
        end
        for (k = 0; k < FOOTER_LEN; k++) foot[k] = t_byte'($urandom);
        if (flaw != FLAW_NOISE) begin
            foot[F_SIGNATURE] = SIGNATURE_BYTE;
            foot[F_FLAGS_A]   = foot[F_FLAGS_A] & ~FLAGS_A_MASK;
            foot[F_COLOR]     = t_byte'($urandom_range(1, 0));
            foot[F_SIZE]      = code;
            do foot[F_SAVE] = t_byte'($urandom); while (!save_code_ok(foot[F_SAVE]));
            foot[F_FLAGS_B]   = foot[F_FLAGS_B] | FLAGS_B_BIT;
            foot[F_MAPPER]    = t_byte'($urandom_range(1, 0));
        end
        case (flaw)
            FLAW_SIGNATURE: begin
                do foot[F_SIGNATURE] = t_byte'($urandom);
                while (foot[F_SIGNATURE] == SIGNATURE_BYTE);
            end
            FLAW_FLAGS_A: foot[F_FLAGS_A] = foot[F_FLAGS_A] | t_byte'(1 << $urandom_range(3, 0));
            FLAW_COLOR:   foot[F_COLOR] = t_byte'($urandom_range(255, 2));
            FLAW_SAVE: begin
                do foot[F_SAVE] = t_byte'($urandom); while (save_code_ok(foot[F_SAVE]));
            end
            FLAW_FLAGS_B: foot[F_FLAGS_B] = foot[F_FLAGS_B] & ~FLAGS_B_BIT;
            FLAW_MAPPER:  foot[F_MAPPER] = t_byte'($urandom_range(255, 2));
            default: ;
        endcase
        for (k = 0; k < size - FOOTER_LEN; k++) begin
            b    = pick_byte(fill);
            csum = csum + SUM_W'(b);
            send_byte(b, 1'b0);
        end
        for (k = 0; k < F_CSUM_LO; k++) csum = csum + SUM_W'(foot[k]);
        if (flaw != FLAW_NOISE) begin
            // Knock the stored checksum off by a nonzero amount for the checksum flaw.
            {foot[F_CSUM_HI], foot[F_CSUM_LO]} = csum +
                ((flaw == FLAW_CHECKSUM) ? SUM_W'($urandom_range(65535, 1)) : SUM_W'(0));
        end
        for (k = 0; k < FOOTER_LEN; k++) send_byte(foot[k], k == FOOTER_LEN - 1);
    endtask

    // Mostly well-formed images with random content, some short ones and some noise.
    task automatic send_random_image();
        int unsigned kind;
        int unsigned size;
        t_flaw       flaw;
        t_byte       code;
        kind = $urandom_range(9, 0);
        code = ($urandom_range(4, 0) == 0) ? t_byte'($urandom) :
               t_byte'($urandom_range(SIZE_CODE_LAST, 0));
        flaw = FLAW_NONE;
        if (kind < 2)      size = $urandom_range(FOOTER_LEN - 1, 1);
        else if (kind < 5) size = FOOTER_LEN << $urandom_range(1, 0);
        else               size = $urandom_range(2 * FOOTER_LEN, FOOTER_LEN + 1);
        if (kind == 9)
            flaw = FLAW_NOISE;
        else if ($urandom_range(2, 0) == 0)
            flaw = t_flaw'($urandom_range(FLAW_CHECKSUM, FLAW_SIGNATURE));
        send_image(size, flaw, code, FILL_RANDOM);
    endtask

    // ------------------------------------------------------------------
    // Verdict side: ready stalls, checking, watchdog
    // ------------------------------------------------------------------
    // Drop ready in bursts of random length while stalls are enabled.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            stall_left   <= 0;
            out_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (stall_on && $urandom_range(4, 0) == 0) begin
            stall_left   <= $urandom_range(6, 0);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each verdict transaction with the oldest one predicted.
    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got = {out_if.status, out_if.aperture_bytes, out_if.footer_cksum,
                   out_if.image_cksum, out_if.color_flag, out_if.save_kind,
                   out_if.mapper_code, out_if.size_code, out_if.checksum_ok,
                   out_if.footer_ok, out_if.compact_flag, out_if.clock_present};
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("aperture_bytes", 32'(want.aperture_bytes),
                            32'(got.aperture_bytes));
                check_field("footer_cksum", 32'(want.footer_cksum), 32'(got.footer_cksum));
                check_field("image_cksum", 32'(want.image_cksum), 32'(got.image_cksum));
                check_field("color_flag", 32'(want.color_flag), 32'(got.color_flag));
                check_field("save_kind", 32'(want.save_kind), 32'(got.save_kind));
                check_field("mapper_code", 32'(want.mapper_code), 32'(got.mapper_code));
                check_field("size_code", 32'(want.size_code), 32'(got.size_code));
                check_field("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
                check_field("footer_ok", 32'(want.footer_ok), 32'(got.footer_ok));
                check_field("compact_flag", 32'(want.compact_flag), 32'(got.compact_flag));
                check_field("clock_present", 32'(want.clock_present),
                            32'(got.clock_present));
            end
        end
    end

    // End the run if neither side moves a transaction for too long.
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Images under 16 bytes, all-zero and all-ones bytes, and final bytes back
    // to back so a second verdict may have to wait behind a stalled one.
    task automatic test_short_images();
        stall_on = 1'b1;
        gap_odds = 8;
        send_image(1, FLAW_NONE, SIZE_CODE_128K, 8'h00);
        send_image(FOOTER_LEN - 1, FLAW_NONE, SIZE_CODE_128K, 8'hff);
        send_image(7, FLAW_NONE, SIZE_CODE_128K, FILL_RANDOM);
        gap_odds = 0;
        repeat (4) send_image(1, FLAW_NONE, SIZE_CODE_128K, FILL_RANDOM);
    endtask

    // Power-of-two images: accepted whatever the footer holds, but footer_ok
    // must report each broken rule; also the size code extremes.
    task automatic test_footer_rules();
        int f;
        stall_on = 1'b1;
        gap_odds = 8;
        for (f = FLAW_NONE; f <= FLAW_NOISE; f++)
            send_image(FOOTER_LEN, t_flaw'(f), t_byte'($urandom_range(SIZE_CODE_LAST, 0)),
                       FILL_RANDOM);
        send_image(FOOTER_LEN, FLAW_NONE, SIZE_CODE_LAST, FILL_RANDOM);
        send_image(FOOTER_LEN, FLAW_NONE, 8'hff, 8'hff);
        send_image(2 * FOOTER_LEN, FLAW_NONE, SIZE_CODE_LAST + 8'd1, 8'h00);
    endtask

    // Small sizes that are not powers of two: never compact, always rejected.
    task automatic test_odd_sizes();
        stall_on = 1'b1;
        gap_odds = 8;
        send_image(FOOTER_LEN + 1, FLAW_NONE, SIZE_CODE_128K, FILL_RANDOM);
        send_image(2 * FOOTER_LEN + 1, FLAW_NONE, SIZE_CODE_LAST, FILL_RANDOM);
        send_image(3 * FOOTER_LEN, FLAW_COLOR, SIZE_CODE_256K, FILL_RANDOM);
    endtask

    // Random images with idling that changes from image to image.
    task automatic test_random_images();
        int unsigned n;
        for (n = 0; n < 5; n++) begin
            stall_on = $urandom_range(1, 0);
            case ($urandom_range(2, 0))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 10;
            endcase
            send_random_image();
        end
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_steady_stream();
        stall_on = 1'b0;
        gap_odds = 0;
        repeat (2) send_random_image();
    endtask

    initial begin
        in_if.valid        = 1'b0;
        in_if.rom_byte     = '0;
        in_if.end_of_image = 1'b0;
        i_rst_n            = 1'b0;
        clear_image();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_images();
        test_footer_rules();
        test_odd_sizes();
        test_random_images();
        test_steady_stream();

        // Drain: hold valid low, wait for every verdict, then allow the latency.
        in_if.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
